### rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define QRI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is held.
`define QRI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/qri_pkg.sv
// Package with widths, constants, types and helper functions of the quaternion integrator.
`timescale 1ns / 1ps
package qri_pkg;

  localparam int QUAT_WIDTH   = 32;
  localparam int CORDIC_STEPS = 28;
  localparam int RATE_W       = 32;
  localparam int RATE_FRAC    = 24;
  localparam int TS_W         = 32;
  localparam int THR_W        = 30;
  localparam int FRAC_BITS    = 30;
  localparam int SQ_W         = 2 * RATE_W;
  localparam int NORM_W       = SQ_W / 2;
  localparam int SQRT_STEPS   = SQ_W / 2;
  localparam int REM_W        = NORM_W + 2;
  localparam int H_SHIFT      = RATE_FRAC + TS_W - FRAC_BITS + 1;
  localparam int H_W          = NORM_W + TS_W - H_SHIFT;
  localparam int MOD_STEPS    = 5;
  localparam int ANGX_W       = 35;
  localparam int ANG_W        = 34;
  localparam int CW           = 34;
  localparam int DIV_BITS     = 32;
  localparam int NUM_W        = 64;
  localparam int R_W          = DIV_BITS + 1;
  localparam int P_W          = CW + QUAT_WIDTH;
  localparam int S_W          = P_W + 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [TS_W-1:0]  TS_RESET  = 32'd4294967;
  localparam logic [THR_W-1:0] THR_RESET = 30'd11;

  localparam longint TWO_PI_Q30      = 64'sd6746518852;
  localparam longint PI_Q30          = 64'sd3373259426;
  localparam longint HALF_PI_Q30     = 64'sd1686629713;
  localparam longint QUARTER_PI_Q30  = 64'sd843314857;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032875;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP = 1'b0,
    CFG_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [TS_W-1:0]  time_step;
    logic [THR_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] w;
    logic signed [QUAT_WIDTH-1:0] x;
    logic signed [QUAT_WIDTH-1:0] y;
    logic signed [QUAT_WIDTH-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] x;
    logic signed [RATE_W-1:0] y;
    logic signed [RATE_W-1:0] z;
  } rate_t;

  typedef struct packed {
    quat_t q;
    rate_t r;
  } side_t;

  typedef struct packed {
    quat_t                   q;
    rate_t                   r;
    logic [NORM_W-1:0]       norm;
    logic signed [ANG_W-1:0] ang;
    logic                    neg_cos;
    logic                    hold;
  } job_t;

  function automatic logic [RATE_W-1:0] rate_mag(input logic signed [RATE_W-1:0] v);
    logic [RATE_W-1:0] m;
    m = v[RATE_W-1] ? RATE_W'(-v) : RATE_W'(v);
    return m;
  endfunction

  // Arctangent of 2^-i in Q.30 from its power series at 60 fraction bits.
  function automatic longint atan_q30(input int i);
    longint          acc;
    longint          t;
    longint unsigned num;
    int              e;
    acc = 0;
    if (i == 0) return QUARTER_PI_Q30;
    if (i > 60) return 0;
    for (int k = 0; k < 31; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        num = 64'd1 << (60 - e);
        t   = longint'(num / 64'(2 * k + 1));
        acc = k[0] ? acc - t : acc + t;
      end
    end
    return (acc + (64'sd1 <<< 29)) >>> 30;
  endfunction

endpackage

### rtl/qri_in_if.sv
// Input channel interface: orientation quaternion and angular rate.
`timescale 1ns / 1ps
interface qri_in_if import qri_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [QUAT_WIDTH-1:0] cur_w;
  logic signed [QUAT_WIDTH-1:0] cur_x;
  logic signed [QUAT_WIDTH-1:0] cur_y;
  logic signed [QUAT_WIDTH-1:0] cur_z;
  logic signed [RATE_W-1:0]     rate_x;
  logic signed [RATE_W-1:0]     rate_y;
  logic signed [RATE_W-1:0]     rate_z;

  modport source (output valid, cur_w, cur_x, cur_y, cur_z, rate_x, rate_y, rate_z,
                  input ready);
  modport sink (input valid, cur_w, cur_x, cur_y, cur_z, rate_x, rate_y, rate_z,
                output ready);
endinterface

### rtl/qri_out_if.sv
// Output channel interface: advanced orientation quaternion.
`timescale 1ns / 1ps
interface qri_out_if import qri_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [QUAT_WIDTH-1:0] next_w;
  logic signed [QUAT_WIDTH-1:0] next_x;
  logic signed [QUAT_WIDTH-1:0] next_y;
  logic signed [QUAT_WIDTH-1:0] next_z;

  modport source (output valid, next_w, next_x, next_y, next_z, input ready);
  modport sink (input valid, next_w, next_x, next_y, next_z, output ready);
endinterface

### rtl/quaternion_rotation_integrate_unit.sv
// Top level of the quaternion exponential-map integrator.
// Use: present one item per cycle on in_i (current quaternion, Q1.30, and the
// angular rate, Q8.24 rad/s); each item yields one advanced quaternion on out_o.
// Both channels use valid and ready; an item moves when both are high.
// The configuration port writes the time step (index 0) or the small-angle
// threshold (index 1); the user must do so only while the block is idle,
// which the block itself does not enforce. Throughput is one item per
// cycle while out_o.ready stays high. The front pipeline holds the
// bit-serial square root; a queue then leads to the back pipeline (28 CORDIC
// stages and a 32-stage restoring divider for the rotation axis).
// When the receiver holds ready low, the back pipeline freezes with its
// result in the output register, while the front keeps accepting items
// until the four-entry queue fills; then in_i.ready drops.
// Reset empties both pipelines and the queue, and loads the time step with
// about 1 ms and the threshold with 11.
`timescale 1ns / 1ps
module quaternion_rotation_integrate_unit import qri_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  qri_in_if.sink                in_i,
  qri_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  job_t f_job, q_job;
  logic f_valid, q_full, q_empty, b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step <= TS_RESET;
      cfg_q.threshold <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TIME_STEP: cfg_q.time_step <= cfg_data_i[TS_W-1:0];
        CFG_THRESHOLD: cfg_q.threshold <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  qri_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .job_o       (f_job),
    .job_valid_o (f_valid),
    .job_ready_i (!q_full)
  );

  qri_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_valid),
    .push_data_i (f_job),
    .full_o      (q_full),
    .pop_i       (b_ready),
    .pop_data_o  (q_job),
    .empty_o     (q_empty)
  );

  qri_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .job_valid_i (!q_empty),
    .job_ready_o (b_ready),
    .out_o       (out_o)
  );

endmodule

### rtl/qri_fifo.sv
// Short queue of classified items between the front and back pipelines.
`timescale 1ns / 1ps
module qri_fifo import qri_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### rtl/qri_front.sv
// Front pipeline: rate norm, half angle, small-angle test and angle reduction.
`timescale 1ns / 1ps
module qri_front import qri_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  qri_in_if.sink in_i,
  input  cfg_t  cfg_i,
  output job_t  job_o,
  output logic  job_valid_o,
  input  logic  job_ready_i
);

  localparam logic signed [ANGX_W-1:0] PI_A      = ANGX_W'(PI_Q30);
  localparam logic signed [ANGX_W-1:0] TWO_PI_A  = ANGX_W'(TWO_PI_Q30);
  localparam logic signed [ANGX_W-1:0] HALF_PI_A = ANGX_W'(HALF_PI_Q30);

  logic  adv;
  side_t in_side;

  assign adv        = !job_valid_o || job_ready_i;
  assign in_i.ready = adv;

  always_comb begin
    in_side.q.w = in_i.cur_w;
    in_side.q.x = in_i.cur_x;
    in_side.q.y = in_i.cur_y;
    in_side.q.z = in_i.cur_z;
    in_side.r.x = in_i.rate_x;
    in_side.r.y = in_i.rate_y;
    in_side.r.z = in_i.rate_z;
  end

  // Input register.
  logic  v1_q;
  side_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) s1_q <= in_side;
  end

  // Squares of the rate magnitudes.
  logic            v2_q;
  side_t           s2_q;
  logic [SQ_W-1:0] sq2_q [3];
  logic [RATE_W-1:0] mag_x, mag_y, mag_z;

  assign mag_x = rate_mag(s1_q.r.x);
  assign mag_y = rate_mag(s1_q.r.y);
  assign mag_z = rate_mag(s1_q.r.z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q     <= s1_q;
      sq2_q[0] <= SQ_W'(mag_x) * SQ_W'(mag_x);
      sq2_q[1] <= SQ_W'(mag_y) * SQ_W'(mag_y);
      sq2_q[2] <= SQ_W'(mag_z) * SQ_W'(mag_z);
    end
  end

  // Sum of squares feeds the square root pipeline, one root bit per stage.
  logic              sv_q   [SQRT_STEPS+1];
  side_t             ss_q   [SQRT_STEPS+1];
  logic [SQ_W-1:0]   rad_q  [SQRT_STEPS+1];
  logic [REM_W-1:0]  rem_q  [SQRT_STEPS+1];
  logic [NORM_W-1:0] root_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (adv) sv_q[0] <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ss_q[0]   <= s2_q;
      rad_q[0]  <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [REM_W:0] rem_t;
    logic [REM_W:0] trial;
    logic           ge;
    logic [REM_W:0] diff;

    assign rem_t = {rem_q[j][REM_W-2:0], rad_q[j][SQ_W-1 -: 2]};
    assign trial = (REM_W+1)'({root_q[j], 2'b01});
    assign ge    = rem_t >= trial;
    assign diff  = rem_t - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[j+1] <= 1'b0;
      else if (adv) sv_q[j+1] <= sv_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ss_q[j+1]   <= ss_q[j];
        rad_q[j+1]  <= rad_q[j] << 2;
        rem_q[j+1]  <= ge ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
        root_q[j+1] <= {root_q[j][NORM_W-2:0], ge};
      end
    end
  end

  // Half angle from the norm and the time step.
  logic                    vh_q;
  side_t                   sh_q;
  logic [NORM_W-1:0]       nh_q;
  logic [H_W-1:0]          h_q;
  logic [NORM_W+TS_W-1:0]  hprod;

  assign hprod = (NORM_W+TS_W)'(root_q[SQRT_STEPS]) * (NORM_W+TS_W)'(cfg_i.time_step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vh_q <= 1'b0;
    else if (adv) vh_q <= sv_q[SQRT_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sh_q <= ss_q[SQRT_STEPS];
      nh_q <= root_q[SQRT_STEPS];
      h_q  <= hprod[NORM_W+TS_W-1:H_SHIFT];
    end
  end

  // Small-angle test, then reduction modulo two pi by conditional subtraction.
  logic              mv_q [MOD_STEPS+1];
  side_t             ms_q [MOD_STEPS+1];
  logic [NORM_W-1:0] mn_q [MOD_STEPS+1];
  logic [H_W-1:0]    mh_q [MOD_STEPS+1];
  logic              mk_q [MOD_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mv_q[0] <= 1'b0;
    else if (adv) mv_q[0] <= vh_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ms_q[0] <= sh_q;
      mn_q[0] <= nh_q;
      mh_q[0] <= h_q;
      mk_q[0] <= h_q < H_W'(cfg_i.threshold);
    end
  end

  for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
    localparam logic [H_W-1:0] MOD_M = H_W'(TWO_PI_Q30 << (MOD_STEPS - 1 - k));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) mv_q[k+1] <= 1'b0;
      else if (adv) mv_q[k+1] <= mv_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ms_q[k+1] <= ms_q[k];
        mn_q[k+1] <= mn_q[k];
        mk_q[k+1] <= mk_q[k];
        mh_q[k+1] <= (mh_q[k] >= MOD_M) ? mh_q[k] - MOD_M : mh_q[k];
      end
    end
  end

  // Move the angle to (-pi, pi] and fold it into [-pi/2, pi/2].
  logic                     fv_q;
  job_t                     fj_q;
  logic signed [ANGX_W-1:0] a0, a1, a2;
  logic                     fneg;

  always_comb begin
    a0   = $signed({1'b0, mh_q[MOD_STEPS][ANGX_W-2:0]});
    a1   = (a0 > PI_A) ? a0 - TWO_PI_A : a0;
    a2   = a1;
    fneg = 1'b0;
    if (a1 > HALF_PI_A) begin
      a2   = PI_A - a1;
      fneg = 1'b1;
    end else if (a1 < -HALF_PI_A) begin
      a2   = -PI_A - a1;
      fneg = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fv_q <= 1'b0;
    else if (adv) fv_q <= mv_q[MOD_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fj_q.q       <= ms_q[MOD_STEPS].q;
      fj_q.r       <= ms_q[MOD_STEPS].r;
      fj_q.norm    <= mn_q[MOD_STEPS];
      fj_q.ang     <= a2[ANG_W-1:0];
      fj_q.neg_cos <= fneg;
      fj_q.hold    <= mk_q[MOD_STEPS];
    end
  end

  assign job_o       = fj_q;
  assign job_valid_o = fv_q;

endmodule

### rtl/qri_back.sv
// Back pipeline: CORDIC sine and cosine, axis division and Hamilton product.
`timescale 1ns / 1ps
module qri_back import qri_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t job_i,
  input  logic job_valid_i,
  output logic job_ready_o,
  qri_out_if.source out_o
);

  localparam logic signed [CW-1:0] GAIN_C   = CW'(CORDIC_GAIN_Q30);
  localparam logic [15:0]          HAM_NEG  = 16'b0100_0010_1000_1110;
  localparam logic signed [S_W-1:0] ROUND_C = S_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [S_W-1:0] SAT_HI  = S_W'((64'sd1 <<< (QUAT_WIDTH - 1)) - 1);
  localparam logic signed [S_W-1:0] SAT_LO  = -SAT_HI - S_W'(1);

  logic  adv;
  logic  ov_q;
  quat_t o_q;

  assign adv         = !ov_q || out_o.ready;
  assign job_ready_o = adv;

  // CORDIC rotation, one micro-rotation per stage.
  logic               cv_q [CORDIC_STEPS+1];
  job_t               cj_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] cx_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] cy_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] cz_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cv_q[0] <= 1'b0;
    else if (adv) cv_q[0] <= job_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cj_q[0] <= job_i;
      cx_q[0] <= GAIN_C;
      cy_q[0] <= '0;
      cz_q[0] <= CW'(job_i.ang);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [CW-1:0] ATAN_C = CW'(atan_q30(i));
    logic signed [CW-1:0] dx, dy;

    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cv_q[i+1] <= 1'b0;
      else if (adv) cv_q[i+1] <= cv_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cj_q[i+1] <= cj_q[i];
        if (!cz_q[i][CW-1]) begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - ATAN_C;
        end else begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + ATAN_C;
        end
      end
    end
  end

  // Sine times each rate component, then restoring division by the norm.
  logic                   dv_q  [DIV_BITS+1];
  job_t                   dj_q  [DIV_BITS+1];
  logic signed [CW-1:0]   d0_q  [DIV_BITS+1];
  logic [NUM_W-1:0]       drm_q [DIV_BITS+1][3];
  logic [DIV_BITS-1:0]    dqt_q [DIV_BITS+1][3];
  logic                   dng_q [DIV_BITS+1][3];
  logic signed [CW+RATE_W-1:0] yw [3];
  logic signed [CW-1:0]   ysin;
  logic signed [CW-1:0]   xcos;

  assign ysin  = cy_q[CORDIC_STEPS];
  assign xcos  = cj_q[CORDIC_STEPS].neg_cos ? -cx_q[CORDIC_STEPS] : cx_q[CORDIC_STEPS];
  assign yw[0] = ysin * $signed(cj_q[CORDIC_STEPS].r.x);
  assign yw[1] = ysin * $signed(cj_q[CORDIC_STEPS].r.y);
  assign yw[2] = ysin * $signed(cj_q[CORDIC_STEPS].r.z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else if (adv) dv_q[0] <= cv_q[CORDIC_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dj_q[0] <= cj_q[CORDIC_STEPS];
      d0_q[0] <= xcos;
      for (int v = 0; v < 3; v++) begin
        drm_q[0][v] <= yw[v][CW+RATE_W-1] ? NUM_W'(-yw[v]) : NUM_W'(yw[v]);
        dqt_q[0][v] <= '0;
        dng_q[0][v] <= yw[v][CW+RATE_W-1];
      end
    end
  end

  for (genvar d = 0; d < DIV_BITS; d++) begin : g_div
    localparam int BIT = DIV_BITS - 1 - d;
    logic [NUM_W-1:0] sub;
    logic [2:0]       ge;

    assign sub = NUM_W'(dj_q[d].norm) << BIT;
    for (genvar v = 0; v < 3; v++) begin : g_lane
      assign ge[v] = drm_q[d][v] >= sub;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[d+1] <= 1'b0;
      else if (adv) dv_q[d+1] <= dv_q[d];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dj_q[d+1] <= dj_q[d];
        d0_q[d+1] <= d0_q[d];
        for (int v = 0; v < 3; v++) begin
          drm_q[d+1][v] <= ge[v] ? drm_q[d][v] - sub : drm_q[d][v];
          dqt_q[d+1][v] <= {dqt_q[d][v][DIV_BITS-2:0], ge[v]};
          dng_q[d+1][v] <= dng_q[d][v];
        end
      end
    end
  end

  // Signed rotation quaternion.
  logic                 hv_q;
  job_t                 hj_q;
  logic signed [CW-1:0] hr_q [4];
  logic signed [R_W-1:0] rax [3];
  logic                 nz;

  assign nz = (dj_q[DIV_BITS].norm != '0);
  for (genvar v = 0; v < 3; v++) begin : g_axis
    assign rax[v] = !nz ? '0 :
                    dng_q[DIV_BITS][v] ? -$signed({1'b0, dqt_q[DIV_BITS][v]}) :
                                         $signed({1'b0, dqt_q[DIV_BITS][v]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hv_q <= 1'b0;
    else if (adv) hv_q <= dv_q[DIV_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hj_q    <= dj_q[DIV_BITS];
      hr_q[0] <= d0_q[DIV_BITS];
      hr_q[1] <= CW'(rax[0]);
      hr_q[2] <= CW'(rax[1]);
      hr_q[3] <= CW'(rax[2]);
    end
  end

  // Sixteen partial products of the Hamilton product.
  logic                  pv_q;
  job_t                  pj_q;
  logic signed [P_W-1:0] pp_q [4][4];
  logic signed [QUAT_WIDTH-1:0] hq [4];

  assign hq[0] = hj_q.q.w;
  assign hq[1] = hj_q.q.x;
  assign hq[2] = hj_q.q.y;
  assign hq[3] = hj_q.q.z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else if (adv) pv_q <= hv_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pj_q <= hj_q;
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) begin
          pp_q[c][k] <= hr_q[k] * hq[(c ^ k) & 3];
        end
      end
    end
  end

  // Pairwise sums with the component signs applied.
  logic                  av_q;
  job_t                  aj_q;
  logic signed [S_W-1:0] pa_q [4];
  logic signed [S_W-1:0] pb_q [4];
  logic signed [S_W-1:0] tm [4][4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        tm[c][k] = HAM_NEG[c*4+k] ? -S_W'(pp_q[c][k]) : S_W'(pp_q[c][k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) av_q <= 1'b0;
    else if (adv) av_q <= pv_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      aj_q <= pj_q;
      for (int c = 0; c < 4; c++) begin
        pa_q[c] <= tm[c][0] + tm[c][1];
        pb_q[c] <= tm[c][2] + tm[c][3];
      end
    end
  end

  // Final sum, rounding, saturation and the output register.
  logic signed [S_W-1:0]        tot [4];
  logic signed [S_W-1:0]        shf [4];
  logic signed [QUAT_WIDTH-1:0] sat [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      tot[c] = pa_q[c] + pb_q[c] + ROUND_C;
      shf[c] = tot[c] >>> FRAC_BITS;
      if (shf[c] > SAT_HI) sat[c] = SAT_HI[QUAT_WIDTH-1:0];
      else if (shf[c] < SAT_LO) sat[c] = SAT_LO[QUAT_WIDTH-1:0];
      else sat[c] = shf[c][QUAT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= av_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (aj_q.hold) begin
        o_q <= aj_q.q;
      end else begin
        o_q.w <= sat[0];
        o_q.x <= sat[1];
        o_q.y <= sat[2];
        o_q.z <= sat[3];
      end
    end
  end

  assign out_o.valid  = ov_q;
  assign out_o.next_w = o_q.w;
  assign out_o.next_x = o_q.x;
  assign out_o.next_y = o_q.y;
  assign out_o.next_z = o_q.z;

endmodule

### rtl/qri_checker.sv
// Port-level assertions for the quaternion integrator and their binding.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qri_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  `QRI_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `QRI_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !out_valid_i, "result right after reset")
  `QRI_ASSERT(a_rst_empty2, clk_i, rst_ni, $past(!rst_ni, 2) |-> !out_valid_i, "early result")
  `QRI_ASSERT(a_in_known, clk_i, rst_ni, in_valid_i && in_ready_i |-> !$isunknown(out_valid_i), "unknown output valid")

endmodule

bind quaternion_rotation_integrate_unit qri_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

### tb/tb_top.sv
// Self-checking testbench for the quaternion exponential-map integrator.
`timescale 1ns / 1ps
module tb_top;
  import qri_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_e cfg_idx = CFG_TIME_STEP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  qri_in_if in_ch ();
  qri_out_if out_ch ();

  quaternion_rotation_integrate_unit uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [TS_W-1:0]  step_reg = TS_RESET;
  logic [THR_W-1:0] thr_reg = THR_RESET;
  side_t pending_items[$];
  quat_t expected_quats[$];
  int    mismatches = 0;
  int    accepted = 0;
  int    held_count = 0;
  int    rotated_count = 0;
  int    checked = 0;
  bit    quiet = 1'b0;
  int    in_gap = 0;
  int    out_stall = 0;
  longint arctan_tab[CORDIC_STEPS];
  longint unsigned cycles = 0;

  function automatic longint arctan_step(int i);
    longint acc;
    longint unsigned num;
    int e;
    acc = 0;
    if (i == 0) return QUARTER_PI_Q30;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > 60) break;
      num = 64'd1 << (60 - e);
      acc = k[0] ? acc - longint'(num / 64'(2 * k + 1)) : acc + longint'(num / 64'(2 * k + 1));
    end
    return (acc + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [QUAT_WIDTH-1:0] clamp_q(longint v);
    longint hi;
    hi = (64'sd1 <<< (QUAT_WIDTH - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[QUAT_WIDTH-1:0];
  endfunction

  function automatic void advance_quat(input side_t it, output quat_t res, output bit held);
    longint q[4];
    longint w[3];
    longint r[4];
    longint s[4];
    longint unsigned sq;
    longint unsigned mg;
    longint unsigned norm;
    longint unsigned h;
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit neg_cos;
    q[0] = it.q.w;
    q[1] = it.q.x;
    q[2] = it.q.y;
    q[3] = it.q.z;
    w[0] = it.r.x;
    w[1] = it.r.y;
    w[2] = it.r.z;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mg = w[i] < 0 ? longint'(-w[i]) : longint'(w[i]);
      sq = sq + mg * mg;
    end
    norm = root_floor(sq);
    h = (((norm >> 32) * 64'(step_reg)) << 5) + (((norm & 64'hFFFF_FFFF) * 64'(step_reg)) >> 27);
    held = h < 64'(thr_reg);
    if (held) begin
      res = it.q;
      return;
    end
    neg_cos = 1'b0;
    a = longint'(h % 64'(TWO_PI_Q30));
    if (a > PI_Q30) a = a - TWO_PI_Q30;
    if (a > HALF_PI_Q30) begin
      a = PI_Q30 - a;
      neg_cos = 1'b1;
    end else if (a < -HALF_PI_Q30) begin
      a = -PI_Q30 - a;
      neg_cos = 1'b1;
    end
    x = CORDIC_GAIN_Q30;
    y = 0;
    z = a;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_tab[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_tab[i];
      end
    end
    r[0] = neg_cos ? -x : x;
    for (int i = 0; i < 3; i++) r[1+i] = (norm == 0) ? 0 : (y * w[i]) / longint'(norm);
    s[0] = r[0] * q[0] - r[1] * q[1] - r[2] * q[2] - r[3] * q[3];
    s[1] = r[0] * q[1] + r[1] * q[0] + r[2] * q[3] - r[3] * q[2];
    s[2] = r[0] * q[2] - r[1] * q[3] + r[2] * q[0] + r[3] * q[1];
    s[3] = r[0] * q[3] + r[1] * q[2] - r[2] * q[1] + r[3] * q[0];
    for (int i = 0; i < 4; i++) s[i] = (s[i] + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    res.w = clamp_q(s[0]);
    res.x = clamp_q(s[1]);
    res.y = clamp_q(s[2]);
    res.z = clamp_q(s[3]);
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cur_w = '0;
    in_ch.cur_x = '0;
    in_ch.cur_y = '0;
    in_ch.cur_z = '0;
    in_ch.rate_x = '0;
    in_ch.rate_y = '0;
    in_ch.rate_z = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    side_t it;
    quat_t exp_q;
    bit    held;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        it.q = '{in_ch.cur_w, in_ch.cur_x, in_ch.cur_y, in_ch.cur_z};
        it.r = '{in_ch.rate_x, in_ch.rate_y, in_ch.rate_z};
        advance_quat(it, exp_q, held);
        expected_quats.push_back(exp_q);
        accepted++;
        if (held) held_count++;
        else rotated_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cur_w <= it.q.w;
          in_ch.cur_x <= it.q.x;
          in_ch.cur_y <= it.q.y;
          in_ch.cur_z <= it.q.z;
          in_ch.rate_x <= it.r.x;
          in_ch.rate_y <= it.r.y;
          in_ch.rate_z <= it.r.z;
          if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 6);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    quat_t exp_q;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (expected_quats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: %h %h %h %h", out_ch.next_w,
                                         out_ch.next_x, out_ch.next_y, out_ch.next_z);
        end else begin
          exp_q = expected_quats.pop_front();
          if (out_ch.next_w !== exp_q.w || out_ch.next_x !== exp_q.x ||
              out_ch.next_y !== exp_q.y || out_ch.next_z !== exp_q.z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch item %0d: exp %h %h %h %h got %h %h %h %h", checked,
                       exp_q.w, exp_q.x, exp_q.y, exp_q.z, out_ch.next_w, out_ch.next_x,
                       out_ch.next_y, out_ch.next_z);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_rate();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 31);
  endfunction

  function automatic logic signed [31:0] rand_comp();
    logic signed [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 2) == 0) return v;
    return v >>> $urandom_range(1, 4);
  endfunction

  task automatic add_item(logic signed [31:0] w, logic signed [31:0] x, logic signed [31:0] y,
                          logic signed [31:0] z, logic signed [31:0] rx,
                          logic signed [31:0] ry, logic signed [31:0] rz);
    side_t it;
    it.q = '{w, x, y, z};
    it.r = '{rx, ry, rz};
    pending_items.push_back(it);
  endtask

  task automatic add_random(int n);
    repeat (n) add_item(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                        rand_rate(), rand_rate(), rand_rate());
  endtask

  task automatic add_directed();
    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONE = 32'sh4000_0000;
    add_item(ONE, 0, 0, 0, 0, 0, 0);
    add_item(MAXV, MINV, MAXV, MINV, 0, 0, 0);
    add_item(ONE, 0, 0, 0, 32'sh0100_0000, 0, 0);
    add_item(ONE, 0, 0, 0, 0, 32'sh0100_0000, 0);
    add_item(0, ONE, 0, 0, 0, 0, -32'sh0100_0000);
    add_item(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    add_item(MINV, MINV, MINV, MINV, MINV, MINV, MINV);
    add_item(MAXV, MINV, MINV, MAXV, MINV, MAXV, MINV);
    add_item(32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000, 1, -1, 1);
    add_item(-1, -1, -1, -1, -1, -1, -1);
    add_item(ONE, 32'sh1234_5678, -32'sh0765_4321, 32'sh0FED_CBA9, 32'sh4000_0000, 0, 0);
    add_item(ONE, 0, 0, 0, 32'sh1000_0000, -32'sh2000_0000, 32'sh3000_0000);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    if (idx == CFG_TIME_STEP) step_reg = data;
    else thr_reg = data[THR_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_ch.valid || expected_quats.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < CORDIC_STEPS; i++) arctan_tab[i] = arctan_step(i);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_directed();
    add_random(180);
    wait_idle();
    write_reg(CFG_TIME_STEP, 32'hFFFF_FFFF);
    write_reg(CFG_THRESHOLD, 32'd0);
    add_directed();
    add_random(180);
    wait_idle();
    write_reg(CFG_TIME_STEP, $urandom);
    write_reg(CFG_THRESHOLD, 32'h3FFF_FFFF);
    add_random(100);
    wait_idle();
    write_reg(CFG_TIME_STEP, 32'd0);
    write_reg(CFG_THRESHOLD, 32'd0);
    add_directed();
    add_random(60);
    wait_idle();
    write_reg(CFG_TIME_STEP, $urandom_range(32'h0010_0000, 32'h4000_0000));
    write_reg(CFG_THRESHOLD, $urandom_range(0, 1000));
    add_random(180);
    wait_idle();
    quiet = 1'b1;
    add_random(150);
    wait_idle();
    $display("%0d items checked: %0d rotated, %0d held below the threshold", checked,
             rotated_count, held_count);
    $display("time step and threshold covered reset, extreme and random settings");
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
